@@ src/hsvck_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hsvck_pkg;

  // channel and quotient widths
  localparam int CHANNEL_BITS = 8;
  localparam int SQ_BITS      = CHANNEL_BITS;       // saturation quotient, 0..255
  localparam int HQ_BITS      = CHANNEL_BITS + 1;   // half-hue quotient before wrap, 150..330
  localparam int DIV_W        = CHANNEL_BITS + 1;   // divisors 2*max and 2*diff
  localparam int SREM_W       = 17;                 // 510*diff + max
  localparam int HREM_W       = 18;                 // 2*t + diff, up to 661*diff
  localparam int ACC_W        = 20;                 // signed hue numerator accumulator
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;

  localparam logic [HQ_BITS-1:0] HUE_WRAP = HQ_BITS'(180);
  localparam logic [SREM_W-1:0]  SAT_SCALE = SREM_W'(510);

  // hue numerator coefficients on diff: 2*(offset + 180) + 1
  localparam logic signed [ACC_W-1:0] HUE_COEF_RED   = ACC_W'(361);
  localparam logic signed [ACC_W-1:0] HUE_COEF_GREEN = ACC_W'(481);
  localparam logic signed [ACC_W-1:0] HUE_COEF_BLUE  = ACC_W'(601);
  localparam logic signed [ACC_W-1:0] HUE_SLOPE      = ACC_W'(60);

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // register reset values
  localparam chan_t HUE_LOWER_RST = 8'd90;
  localparam chan_t HUE_UPPER_RST = 8'd150;
  localparam chan_t SAT_LOWER_RST = 8'd100;
  localparam chan_t SAT_UPPER_RST = 8'd255;
  localparam chan_t VAL_LOWER_RST = 8'd70;
  localparam chan_t VAL_UPPER_RST = 8'd255;

  typedef enum logic [2:0] {
    REG_HUE_LOWER = 3'd0,
    REG_HUE_UPPER = 3'd1,
    REG_SAT_LOWER = 3'd2,
    REG_SAT_UPPER = 3'd3,
    REG_VAL_LOWER = 3'd4,
    REG_VAL_UPPER = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    chan_t pix_blue;
    chan_t pix_green;
    chan_t pix_red;
  } pix_t;

  typedef struct packed {
    chan_t out_blue;
    chan_t out_green;
    chan_t out_red;
    logic  in_range;
  } res_t;

  typedef struct packed {
    chan_t hue_lower;
    chan_t hue_upper;
    chan_t sat_lower;
    chan_t sat_upper;
    chan_t val_lower;
    chan_t val_upper;
  } cfg_t;

  // payload carried through the divider stages
  typedef struct packed {
    pix_t                pix;
    chan_t               v;
    logic                grey;    // max == min, hue forced to 0
    logic                dark;    // max == 0, saturation forced to 0
    logic [SREM_W-1:0]   s_rem;
    logic [DIV_W-1:0]    s_div;
    logic [SQ_BITS-1:0]  s_quo;
    logic [HREM_W-1:0]   h_rem;
    logic [DIV_W-1:0]    h_div;
    logic [HQ_BITS-1:0]  h_quo;
  } dstage_t;

  // range test, wrapping when lower exceeds upper
  function automatic logic in_window(chan_t x, chan_t lo, chan_t hi);
    if (lo <= hi) begin
      return (lo <= x) && (x <= hi);
    end
    return (x <= hi) || (lo <= x);
  endfunction

endpackage

`default_nettype wire

@@ src/hsvck_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hsvck_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ce,
  input  wire logic              in_valid,
  input  wire hsvck_pkg::pix_t   pix,
  output logic                   out_valid,
  output hsvck_pkg::dstage_t     out_data
);
  import hsvck_pkg::*;

  // stage 1: max, min, diff
  logic     valid1;
  pix_t     pix1;
  chan_t    mx1;
  chan_t    diff1;
  max_sel_t sel1;

  chan_t    mx_c;
  chan_t    mn_c;
  max_sel_t sel_c;

  always_comb begin
    mx_c = pix.pix_blue;
    mn_c = pix.pix_blue;
    if (pix.pix_green > mx_c) mx_c = pix.pix_green;
    if (pix.pix_red > mx_c)   mx_c = pix.pix_red;
    if (pix.pix_green < mn_c) mn_c = pix.pix_green;
    if (pix.pix_red < mn_c)   mn_c = pix.pix_red;
    // ties: red over green over blue
    if (mx_c == pix.pix_red) begin
      sel_c = MAX_RED;
    end else if (mx_c == pix.pix_green) begin
      sel_c = MAX_GREEN;
    end else begin
      sel_c = MAX_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ce) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pix1  <= pix;
      mx1   <= mx_c;
      diff1 <= mx_c - mn_c;
      sel1  <= sel_c;
    end
  end

  // stage 2: numerators and divisors
  logic signed [CHANNEL_BITS:0] x_c;
  logic signed [ACC_W-1:0]      coef_c;
  logic signed [ACC_W-1:0]      acc_c;
  logic signed [ACC_W-1:0]      diff_ext;
  dstage_t                      d_c;

  always_comb begin
    case (sel1)
      MAX_RED: begin
        x_c    = $signed({1'b0, pix1.pix_green}) - $signed({1'b0, pix1.pix_blue});
        coef_c = HUE_COEF_RED;
      end
      MAX_GREEN: begin
        x_c    = $signed({1'b0, pix1.pix_blue}) - $signed({1'b0, pix1.pix_red});
        coef_c = HUE_COEF_GREEN;
      end
      default: begin
        x_c    = $signed({1'b0, pix1.pix_red}) - $signed({1'b0, pix1.pix_green});
        coef_c = HUE_COEF_BLUE;
      end
    endcase
    diff_ext = $signed({{(ACC_W-CHANNEL_BITS){1'b0}}, diff1});
    // 2*t + diff, never negative
    acc_c    = ACC_W'(x_c) * HUE_SLOPE + diff_ext * coef_c;

    d_c.pix   = pix1;
    d_c.v     = mx1;
    d_c.grey  = (diff1 == '0);
    d_c.dark  = (mx1 == '0);
    d_c.s_rem = SREM_W'(diff1) * SAT_SCALE + SREM_W'(mx1);
    d_c.s_div = {mx1, 1'b0};
    d_c.s_quo = '0;
    d_c.h_rem = acc_c[HREM_W-1:0];
    d_c.h_div = {diff1, 1'b0};
    d_c.h_quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data <= d_c;
    end
  end

endmodule

`default_nettype wire

@@ src/hsvck_div_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One restoring-division step for both the saturation and the hue quotient.
module hsvck_div_step #(
  parameter int BIT = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                ce,
  input  wire logic                in_valid,
  input  wire hsvck_pkg::dstage_t  in_data,
  output logic                     out_valid,
  output hsvck_pkg::dstage_t       out_data
);
  import hsvck_pkg::*;

  logic [SREM_W-1:0]  s_rem_n;
  logic [SQ_BITS-1:0] s_quo_n;
  logic [HREM_W-1:0]  h_rem_n;
  logic [HQ_BITS-1:0] h_quo_n;
  logic [HREM_W-1:0]  h_sub;
  dstage_t            d_c;

  // saturation quotient has one bit fewer than hue
  if (BIT < SQ_BITS) begin : g_sat
    logic [SREM_W-1:0] s_sub;
    always_comb begin
      s_sub   = SREM_W'(in_data.s_div) << BIT;
      s_rem_n = in_data.s_rem;
      s_quo_n = in_data.s_quo;
      if (in_data.s_rem >= s_sub) begin
        s_rem_n      = in_data.s_rem - s_sub;
        s_quo_n[BIT] = 1'b1;
      end
    end
  end else begin : g_sat_pass
    assign s_rem_n = in_data.s_rem;
    assign s_quo_n = in_data.s_quo;
  end

  // hue quotient bit
  always_comb begin
    h_sub   = HREM_W'(in_data.h_div) << BIT;
    h_rem_n = in_data.h_rem;
    h_quo_n = in_data.h_quo;
    if (in_data.h_rem >= h_sub) begin
      h_rem_n      = in_data.h_rem - h_sub;
      h_quo_n[BIT] = 1'b1;
    end
  end

  always_comb begin
    d_c       = in_data;
    d_c.s_rem = s_rem_n;
    d_c.s_quo = s_quo_n;
    d_c.h_rem = h_rem_n;
    d_c.h_quo = h_quo_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data <= d_c;
    end
  end

endmodule

`default_nettype wire

@@ src/hsvck_key.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Hue wrap, range tests and the output register.
module hsvck_key (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                ce,
  input  wire logic                in_valid,
  input  wire hsvck_pkg::dstage_t  in_data,
  input  wire hsvck_pkg::cfg_t     cfg,
  output logic                     out_valid,
  output hsvck_pkg::res_t          res
);
  import hsvck_pkg::*;

  logic [HQ_BITS-1:0] h_wrap;
  chan_t              hue;
  chan_t              sat;
  logic               hit;
  res_t               res_c;

  always_comb begin
    // rounded half-hue lies in 150..330; fold into 0..179
    if (in_data.h_quo >= HUE_WRAP) begin
      h_wrap = in_data.h_quo - HUE_WRAP;
    end else begin
      h_wrap = in_data.h_quo;
    end
    hue = in_data.grey ? '0 : h_wrap[CHANNEL_BITS-1:0];
    sat = in_data.dark ? '0 : in_data.s_quo;
    hit = in_window(hue, cfg.hue_lower, cfg.hue_upper) &&
          in_window(sat, cfg.sat_lower, cfg.sat_upper) &&
          in_window(in_data.v, cfg.val_lower, cfg.val_upper);

    res_c.out_blue  = hit ? '0 : in_data.pix.pix_blue;
    res_c.out_green = hit ? '0 : in_data.pix.pix_green;
    res_c.out_red   = hit ? '0 : in_data.pix.pix_red;
    res_c.in_range  = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res <= res_c;
    end
  end

endmodule

`default_nettype wire

@@ src/hsv_range_color_key_top.sv @@
// Pipeline: 2 front stages, 9 divider stages at one quotient bit each, and 1
// keying/output stage.
// Throughput: one pixel per cycle; the whole pipeline advances together and holds
// while a result waits at the output register.
// Reset (rst, synchronous): pipeline emptied, range registers back to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module hsv_range_color_key_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire hsvck_pkg::pix_t                   pix,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output hsvck_pkg::res_t                        res,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hsvck_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [hsvck_pkg::PDATA_W-1:0]     pwdata,
  output logic [hsvck_pkg::PDATA_W-1:0]          prdata,
  output logic                                   pready
);
  import hsvck_pkg::*;

  // configuration registers
  cfg_t     cfg;
  reg_idx_t reg_sel;
  chan_t    wr_val;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_val  = pwdata[CHANNEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_lower <= HUE_LOWER_RST;
      cfg.hue_upper <= HUE_UPPER_RST;
      cfg.sat_lower <= SAT_LOWER_RST;
      cfg.sat_upper <= SAT_UPPER_RST;
      cfg.val_lower <= VAL_LOWER_RST;
      cfg.val_upper <= VAL_UPPER_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_HUE_LOWER: cfg.hue_lower <= wr_val;
        REG_HUE_UPPER: cfg.hue_upper <= wr_val;
        REG_SAT_LOWER: cfg.sat_lower <= wr_val;
        REG_SAT_UPPER: cfg.sat_upper <= wr_val;
        REG_VAL_LOWER: cfg.val_lower <= wr_val;
        REG_VAL_UPPER: cfg.val_upper <= wr_val;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_HUE_LOWER: prdata = PDATA_W'(cfg.hue_lower);
      REG_HUE_UPPER: prdata = PDATA_W'(cfg.hue_upper);
      REG_SAT_LOWER: prdata = PDATA_W'(cfg.sat_lower);
      REG_SAT_UPPER: prdata = PDATA_W'(cfg.sat_upper);
      REG_VAL_LOWER: prdata = PDATA_W'(cfg.val_lower);
      REG_VAL_UPPER: prdata = PDATA_W'(cfg.val_upper);
      default:       prdata = '0;
    endcase
  end

  // pipeline advance: output register empty or being drained
  logic ce;
  assign ce       = !out_valid || out_ready;
  assign in_ready = ce;

  logic    stg_valid [HQ_BITS+1];
  dstage_t stg_data  [HQ_BITS+1];

  hsvck_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (in_valid),
    .pix       (pix),
    .out_valid (stg_valid[0]),
    .out_data  (stg_data[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar k = 0; k < HQ_BITS; k++) begin : g_div
    hsvck_div_step #(
      .BIT (HQ_BITS - 1 - k)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (stg_valid[k]),
      .in_data   (stg_data[k]),
      .out_valid (stg_valid[k+1]),
      .out_data  (stg_data[k+1])
    );
  end

  hsvck_key u_key (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (stg_valid[HQ_BITS]),
    .in_data   (stg_data[HQ_BITS]),
    .cfg       (cfg),
    .out_valid (out_valid),
    .res       (res)
  );

endmodule

`default_nettype wire

@@ test/hsv_range_color_key_top_tb.sv @@
`timescale 1ns / 1ps

module hsv_range_color_key_top_tb;
  import hsvck_pkg::*;

  localparam int LATENCY      = 12;
  localparam int NUM_KEY_REGS = 6;
  // longest run of cycles with no transaction on either side; a correct run
  // stays far below this even with long output stalls
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    chan_t h;
    chan_t s;
    chan_t v;
  } hsv_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  pix_t                 pix       = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  res_t                 res;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [PADDR_W-1:0]   paddr     = '0;
  logic [PDATA_W-1:0]   pwdata    = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // predictor copy of the range registers
  cfg_t key_cfg = '{HUE_LOWER_RST, HUE_UPPER_RST, SAT_LOWER_RST,
                    SAT_UPPER_RST, VAL_LOWER_RST, VAL_UPPER_RST};
  res_t keyed_q[$];
  res_t want;
  int   send_gap_pct   = 0;
  int   recv_stall_pct = 0;
  int   mismatches     = 0;
  int   idle_cycles    = 0;

  hsv_range_color_key_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pix(pix),
    .out_valid(out_valid), .out_ready(out_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // inclusive range, wrapping around when the lower bound is above the upper
  function automatic bit in_band(chan_t x, chan_t lo, chan_t hi);
    return (lo <= hi) ? (x >= lo && x <= hi) : (x >= lo || x <= hi);
  endfunction

  function automatic hsv_t pixel_hsv(pix_t p);
    int   b, g, r, top, bot, span, num;
    hsv_t c;
    b = p.pix_blue;
    g = p.pix_green;
    r = p.pix_red;
    top = (b > g) ? b : g;
    top = (r > top) ? r : top;
    bot = (b < g) ? b : g;
    bot = (r < bot) ? r : bot;
    span = top - bot;
    c.v = chan_t'(top);
    c.s = (top == 0) ? chan_t'(0) : chan_t'((510 * span + top) / (2 * top));
    if (span == 0) begin
      c.h = '0;
    end else begin
      // half-hue scaled by span; red max beats green, green beats blue
      if (top == r) begin
        num = 30 * (g - b);
      end else if (top == g) begin
        num = 30 * (b - r) + 60 * span;
      end else begin
        num = 30 * (r - g) + 120 * span;
      end
      num += 180 * span;
      c.h = chan_t'(((2 * num + span) / (2 * span)) % 180);
    end
    return c;
  endfunction

  function automatic res_t key_pixel(pix_t p);
    hsv_t c;
    res_t e;
    c = pixel_hsv(p);
    e.in_range = in_band(c.h, key_cfg.hue_lower, key_cfg.hue_upper) &&
                 in_band(c.s, key_cfg.sat_lower, key_cfg.sat_upper) &&
                 in_band(c.v, key_cfg.val_lower, key_cfg.val_upper);
    e.out_blue  = e.in_range ? chan_t'(0) : p.pix_blue;
    e.out_green = e.in_range ? chan_t'(0) : p.pix_green;
    e.out_red   = e.in_range ? chan_t'(0) : p.pix_red;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog (sampled mid-cycle, ahead of the edge)
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input res_t exp_r, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected bgr=%02h/%02h/%02h key=%0b, got bgr=%02h/%02h/%02h key=%0b",
               $time, what, exp_r.out_blue, exp_r.out_green, exp_r.out_red, exp_r.in_range,
               got.out_blue, got.out_green, got.out_red, got.in_range);
    end
  endtask

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (keyed_q.size() == 0) begin
        report_mismatch("result transaction with no pixel pending", '0, res);
      end else begin
        want = keyed_q.pop_front();
        if (res.out_blue !== want.out_blue || res.out_green !== want.out_green ||
            res.out_red !== want.out_red || res.in_range !== want.in_range) begin
          report_mismatch("keyed pixel mismatch", want, res);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic send_pixel(input pix_t p);
    bit taken;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    pix      <= p;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    keyed_q.push_back(key_pixel(p));
  endtask

  // drop valid and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (keyed_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one APB write: setup cycle, then access until pready; upper data bits are junk
  task automatic write_bound(input int unsigned idx, input chan_t value);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HUE_LOWER: key_cfg.hue_lower = value;
      REG_HUE_UPPER: key_cfg.hue_upper = value;
      REG_SAT_LOWER: key_cfg.sat_lower = value;
      REG_SAT_UPPER: key_cfg.sat_upper = value;
      REG_VAL_LOWER: key_cfg.val_lower = value;
      REG_VAL_UPPER: key_cfg.val_upper = value;
      default: ;  // unmapped address, write dropped
    endcase
  endtask

  task automatic set_bounds(input chan_t h_lo, input chan_t h_hi, input chan_t s_lo,
                            input chan_t s_hi, input chan_t v_lo, input chan_t v_hi);
    wait_idle();
    write_bound(REG_HUE_LOWER, h_lo);
    write_bound(REG_HUE_UPPER, h_hi);
    write_bound(REG_SAT_LOWER, s_lo);
    write_bound(REG_SAT_UPPER, s_hi);
    write_bound(REG_VAL_LOWER, v_lo);
    write_bound(REG_VAL_UPPER, v_hi);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pix_t random_pixel();
    pix_t  p;
    chan_t a;
    p = pix_t'(24'($urandom));
    case ($urandom_range(5))
      0: begin
        a = chan_t'($urandom);
        p = '{a, a, a};
      end
      1: p.pix_green = p.pix_red;
      2: p.pix_blue = p.pix_green;
      3: begin
        p.pix_red   = $urandom_range(1) ? 8'hFF : 8'h00;
        p.pix_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic chan_t edge_bound();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd179;
      3: return 8'd180;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset bounds: hue 90..150, sat 100..255, val 70..255
  task automatic test_default_bounds();
    pix_t corners[13] = '{
      '{8'd0,   8'd0,   8'd0},    // black
      '{8'd255, 8'd255, 8'd255},  // white
      '{8'd255, 8'd0,   8'd0},    // blue, keyed
      '{8'd0,   8'd255, 8'd0},    // green
      '{8'd0,   8'd0,   8'd255},  // red
      '{8'd255, 8'd255, 8'd0},    // cyan, hue at lower bound
      '{8'd255, 8'd0,   8'd255},  // magenta, hue at upper bound
      '{8'd1,   8'd0,   8'd255},  // hue rounds up to 180 and wraps to 0
      '{8'd2,   8'd1,   8'd1},    // saturation exact half
      '{8'd0,   8'd1,   8'd4},    // hue exact half
      '{8'd128, 8'd128, 8'd128},  // grey
      '{8'd70,  8'd0,   8'd0},    // value at lower bound
      '{8'd69,  8'd0,   8'd0}     // value just below
    };
    foreach (corners[i]) send_pixel(corners[i]);
  endtask

  task automatic test_bound_corners();
    // full ranges key everything
    set_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel(random_pixel());
    // equal bounds hold a single value
    set_bounds(8'd120, 8'd120, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd254, 8'd0, 8'd0});
    // wrapped hue around red
    set_bounds(8'd170, 8'd10, 8'd0, 8'd255, 8'd0, 8'd255);
    send_pixel('{8'd0, 8'd0, 8'd255});
    send_pixel('{8'd1, 8'd0, 8'd255});
    send_pixel('{8'd0, 8'd255, 8'd0});
    // wrapped saturation and value
    set_bounds(8'd200, 8'd100, 8'd200, 8'd50, 8'd200, 8'd50);
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd100, 8'd100, 8'd100});
    // hue bounds beyond 179
    set_bounds(8'd180, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    send_pixel('{8'd0, 8'd255, 8'd0});
    set_bounds(8'd200, 8'd190, 8'd0, 8'd255, 8'd0, 8'd255);
    send_pixel('{8'd0, 8'd255, 8'd0});
    // writes past the register map are dropped
    wait_idle();
    write_bound(NUM_KEY_REGS, 8'd0);
    write_bound(NUM_KEY_REGS + 1, 8'd0);
    send_pixel('{8'd0, 8'd200, 8'd10});
  endtask

  task automatic test_random_keying(input int gap_pct, input int stall, input int n_items);
    hsv_t c;
    int   pick;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall;
    for (int blk = 0; blk < 5; blk++) begin
      pick = $urandom_range(3);
      if (pick == 0) begin
        set_bounds(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom),
                   chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
      end else if (pick == 1) begin
        set_bounds(edge_bound(), edge_bound(), edge_bound(),
                   edge_bound(), edge_bound(), edge_bound());
      end else begin
        // window around a random color so that a good share of pixels key out
        c = pixel_hsv(random_pixel());
        set_bounds(chan_t'(c.h - $urandom_range(40)), chan_t'(c.h + $urandom_range(40)),
                   chan_t'(c.s - $urandom_range(80)), chan_t'(c.s + $urandom_range(80)),
                   chan_t'(c.v - $urandom_range(80)), chan_t'(c.v + $urandom_range(80)));
      end
      repeat (n_items / 5) send_pixel(random_pixel());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct   = 26;
    recv_stall_pct = 56;
    test_default_bounds();
    test_bound_corners();
    test_random_keying(26, 56, 250);
    test_random_keying(56, 26, 250);
    test_random_keying(0, 0, 250);
    wait_idle();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && keyed_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
